// ===== hdl/obl_pkg.sv =====
`default_nettype none

package obl_pkg;

   // field widths fixed by the request and response formats
   localparam int SHIFT_W    = 5;
   localparam int LIST_W     = 14;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W = 6;

   // queue depths between the parts
   localparam int CMD_DEPTH = 4;
   localparam int RSP_DEPTH = 2;

   // request operations
   localparam logic OP_WRITE  = 1'b0;
   localparam logic OP_LOOKUP = 1'b1;

   // register indexes of the configuration port
   localparam logic [CSR_INDEX_W-1:0] CSR_BLOCK_WIDTH_SHIFT = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_Z_PLACE_SHIFT     = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_Y_PLACE_SHIFT     = 2'd2;

   // place shift code that selects a single root when both shifts carry it
   localparam logic [CSR_DATA_W-1:0] PLACE_SINGLE = 6'h3F;

   // command kinds passed from the front to the back
   localparam logic [1:0] CMD_WRITE  = 2'd0;
   localparam logic [1:0] CMD_LOOKUP = 2'd1;
   localparam logic [1:0] CMD_FAULT  = 2'd2;

   typedef struct packed {
      logic               operation;
      logic [11:0]        word_index;
      logic signed [31:0] word_value;
      logic [31:0]        coord_x;
      logic [31:0]        coord_y;
      logic [31:0]        coord_z;
   } req_type;

   typedef struct packed {
      logic [LIST_W-1:0]  list_address;
      logic [SHIFT_W-1:0] final_shift;
      logic               error;
   } rsp_type;

   // index holds the write word index or the root word index
   typedef struct packed {
      logic [1:0]         kind;
      logic [SHIFT_W-1:0] shift;
      logic [31:0]        index;
      logic [31:0]        data;
      logic [31:0]        x;
      logic [31:0]        y;
      logic [31:0]        z;
   } cmd_type;

endpackage

`default_nettype wire

// ===== hdl/obl_ram.sv =====
`default_nettype none

module obl_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] storage_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         storage_ff[wr_addr] <= wr_data;
      end
   end

   // registered read, holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= storage_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hdl/obl_fifo.sv =====
`default_nettype none

module obl_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic      [WIDTH-1:0] pop_data,
   output logic                  empty
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entries_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entries_ff[rd_ptr_ff];

   // pointer and occupancy update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/obl_front.sv =====
`default_nettype none

module obl_front #(
   parameter int MEM_WORDS = 4096
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_push,
   input  wire obl_pkg::req_type                   req_data,
   output logic                                    req_full,
   input  wire logic                               csr_valid,
   input  wire logic [obl_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [obl_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output logic                                    cmd_push,
   output obl_pkg::cmd_type                        cmd_data,
   input  wire logic                               cmd_full
);

   import obl_pkg::*;

   logic [SHIFT_W-1:0]    bws_ff;
   logic [CSR_DATA_W-1:0] zps_ff;
   logic [CSR_DATA_W-1:0] yps_ff;
   logic [31:0]           x_sh, y_sh, z_sh, root_index;
   logic                  single_root, place_neg, keep;

   // configuration registers, always ready
   always_ff @(posedge clock) begin
      if (reset) begin
         bws_ff <= '0;
         zps_ff <= '0;
         yps_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_BLOCK_WIDTH_SHIFT: bws_ff <= csr_wdata[SHIFT_W-1:0];
            CSR_Z_PLACE_SHIFT:     zps_ff <= csr_wdata;
            CSR_Y_PLACE_SHIFT:     yps_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // root word index from the scaled coordinates
   assign x_sh        = req_data.coord_x >> bws_ff;
   assign y_sh        = req_data.coord_y >> bws_ff;
   assign z_sh        = req_data.coord_z >> bws_ff;
   assign root_index  = x_sh | (z_sh << zps_ff[SHIFT_W-1:0]) | (y_sh << yps_ff[SHIFT_W-1:0]);
   assign single_root = (zps_ff == PLACE_SINGLE) && (yps_ff == PLACE_SINGLE);
   assign place_neg   = zps_ff[CSR_DATA_W-1] || yps_ff[CSR_DATA_W-1];

   // classify the request into a command for the back end
   always_comb begin
      cmd_data.shift = bws_ff;
      cmd_data.data  = req_data.word_value;
      cmd_data.x     = req_data.coord_x;
      cmd_data.y     = req_data.coord_y;
      cmd_data.z     = req_data.coord_z;
      cmd_data.index = root_index;
      cmd_data.kind  = CMD_LOOKUP;
      keep           = 1'b1;
      priority if (req_data.operation == OP_WRITE) begin
         cmd_data.kind  = CMD_WRITE;
         cmd_data.index = 32'(req_data.word_index);
         keep           = (32'(req_data.word_index) < 32'(MEM_WORDS));
      end else if (single_root) begin
         cmd_data.index = '0;
      end else if (place_neg) begin
         cmd_data.kind = CMD_FAULT;
      end else if (root_index >= 32'(MEM_WORDS)) begin
         cmd_data.kind = CMD_FAULT;
      end else begin
         cmd_data.kind = CMD_LOOKUP;
      end
   end

   // writes beyond the memory are taken and dropped
   assign req_full = cmd_full;
   assign cmd_push = req_push && !cmd_full && keep;

endmodule

`default_nettype wire

// ===== hdl/obl_back.sv =====
`default_nettype none

module obl_back #(
   parameter int MEM_WORDS = 4096
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         cmd_empty,
   input  wire obl_pkg::cmd_type             cmd_data,
   output logic                              cmd_pop,
   input  wire logic                         res_full,
   output logic                              res_push,
   output obl_pkg::rsp_type                  res_data,
   output logic                              ram_wr_en,
   output logic [$clog2(MEM_WORDS)-1:0]      ram_wr_addr,
   output logic [31:0]                       ram_wr_data,
   output logic                              ram_rd_en,
   output logic [$clog2(MEM_WORDS)-1:0]      ram_rd_addr,
   input  wire logic [31:0]                  ram_rd_data
);

   import obl_pkg::*;

   localparam int AW    = $clog2(MEM_WORDS);
   localparam int OFF_W = AW + 2;
   localparam int AT_W  = AW + 3;
   localparam int SUM_W = ((AW + 2) > 31 ? (AW + 2) : 31) + 1;
   localparam logic [AT_W-1:0]  AT_LIMIT  = AT_W'(4 * MEM_WORDS);
   localparam logic [SUM_W-1:0] SUM_LIMIT = SUM_W'(4 * MEM_WORDS);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_ADDR = 2'd1;
   localparam logic [1:0] ST_WAIT = 2'd2;

   logic [1:0]         state_ff, state_in;
   logic [OFF_W-1:0]   base_ff, base_in;
   logic               big_ff, big_in;
   logic [OFF_W-1:0]   offset_ff, offset_in;
   logic [SHIFT_W-1:0] shift_ff, shift_in;
   logic [31:0]        x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic [AT_W-1:0]    at;
   logic               at_bad;
   logic [SUM_W-1:0]   sum;
   logic               leaf_good;

   // byte address of the next word and the sum of base and word
   assign at        = AT_W'(base_ff) + AT_W'(offset_ff);
   assign at_bad    = big_ff || (at[1:0] != 2'b00) || (at >= AT_LIMIT);
   assign sum       = SUM_W'(base_ff) + SUM_W'(ram_rd_data[30:0]);
   assign leaf_good = (sum[1:0] == 2'b00) && (sum < SUM_LIMIT);

   // walk sequencer
   always_comb begin
      state_in    = state_ff;
      base_in     = base_ff;
      big_in      = big_ff;
      offset_in   = offset_ff;
      shift_in    = shift_ff;
      x_in        = x_ff;
      y_in        = y_ff;
      z_in        = z_ff;
      cmd_pop     = 1'b0;
      res_push    = 1'b0;
      res_data    = '{list_address: '0, final_shift: shift_ff, error: 1'b1};
      ram_wr_en   = 1'b0;
      ram_wr_addr = cmd_data.index[AW-1:0];
      ram_wr_data = cmd_data.data;
      ram_rd_en   = 1'b0;
      ram_rd_addr = at[AW+1:2];
      unique case (state_ff)
         ST_IDLE: begin
            if (!cmd_empty) begin
               unique case (cmd_data.kind)
                  CMD_WRITE: begin
                     ram_wr_en = 1'b1;
                     cmd_pop   = 1'b1;
                  end
                  CMD_FAULT: begin
                     res_data.final_shift = cmd_data.shift;
                     if (!res_full) begin
                        res_push = 1'b1;
                        cmd_pop  = 1'b1;
                     end
                  end
                  CMD_LOOKUP: begin
                     cmd_pop   = 1'b1;
                     base_in   = '0;
                     big_in    = 1'b0;
                     offset_in = {cmd_data.index[AW-1:0], 2'b00};
                     shift_in  = cmd_data.shift;
                     x_in      = cmd_data.x;
                     y_in      = cmd_data.y;
                     z_in      = cmd_data.z;
                     state_in  = ST_ADDR;
                  end
                  default: cmd_pop = 1'b1;
               endcase
            end
         end
         ST_ADDR: begin
            if (at_bad) begin
               if (!res_full) begin
                  res_push = 1'b1;
                  state_in = ST_IDLE;
               end
            end else begin
               ram_rd_en = 1'b1;
               state_in  = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (ram_rd_data[31]) begin
               // leaf marker ends the walk
               res_data.list_address = leaf_good ? sum[LIST_W-1:0] : '0;
               res_data.error        = !leaf_good;
               if (!res_full) begin
                  res_push = 1'b1;
                  state_in = ST_IDLE;
               end
            end else if (shift_ff == '0) begin
               if (!res_full) begin
                  res_push = 1'b1;
                  state_in = ST_IDLE;
               end
            end else begin
               // descend one level into the child picked by z, y, x
               base_in   = sum[OFF_W-1:0];
               big_in    = (sum >= SUM_LIMIT);
               shift_in  = shift_ff - 1'b1;
               offset_in = OFF_W'({z_ff[shift_in], y_ff[shift_in], x_ff[shift_in], 2'b00});
               state_in  = ST_ADDR;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // walk context
   always_ff @(posedge clock) begin
      base_ff   <= base_in;
      big_ff    <= big_in;
      offset_ff <= offset_in;
      shift_ff  <= shift_in;
      x_ff      <= x_in;
      y_ff      <= y_in;
      z_ff      <= z_in;
   end

   // memory port is used for one access at a time
   assert property (@(posedge clock) disable iff (reset) !(ram_rd_en && ram_wr_en))
      else $error("read and write issued together");

   // a word is consumed only after its read was issued
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WAIT) |-> ($past(state_ff) == ST_ADDR || $past(state_ff) == ST_WAIT))
      else $error("word consumed without a read");

   // each level down lowers the shift by one
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WAIT && state_in == ST_ADDR) |=> (shift_ff == $past(shift_ff) - 5'd1))
      else $error("shift not lowered on descent");

   // results only go to a queue with room
   assert property (@(posedge clock) disable iff (reset) res_push |-> !res_full)
      else $error("result pushed into a full queue");

endmodule

`default_nettype wire

// ===== hdl/octree_block_lookup_core.sv =====
// flow: a request enters the command queue in its accept cycle; a lookup then walks the
//   octree words, the walk sequencer spending an address check state and a registered memory
//   read state on each word; the back end takes no new command until the walk ends
//   and its response is pushed; a word write is done by the back end from the idle state
// reset: synchronous, active high; clears queues, walker state and configuration registers
//   to 0; octree memory contents are not cleared and are undefined until written
`default_nettype none

module octree_block_lookup_core #(
   parameter int MEM_WORDS = 4096
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_push,
   input  wire obl_pkg::req_type                   req_data,
   output logic                                    req_full,
   output logic                                    rsp_empty,
   input  wire logic                               rsp_pop,
   output obl_pkg::rsp_type                        rsp_data,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [obl_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [obl_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   import obl_pkg::*;

   localparam int AW = $clog2(MEM_WORDS);

   cmd_type          cmd_in, cmd_out;
   logic             cmd_push, cmd_full, cmd_pop, cmd_empty;
   rsp_type          res_in;
   logic             res_push, res_full;
   logic             ram_wr_en, ram_rd_en;
   logic [AW-1:0]    ram_wr_addr, ram_rd_addr;
   logic [31:0]      ram_wr_data, ram_rd_data;

   assign csr_ready = 1'b1;

   // request intake and classification
   obl_front #(.MEM_WORDS(MEM_WORDS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_data  (req_data),
      .req_full  (req_full),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd_push  (cmd_push),
      .cmd_data  (cmd_in),
      .cmd_full  (cmd_full)
   );

   // command queue between front and back
   obl_fifo #(.WIDTH($bits(cmd_type)), .DEPTH(CMD_DEPTH)) u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_in),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .pop_data  (cmd_out),
      .empty     (cmd_empty)
   );

   // tree walker
   obl_back #(.MEM_WORDS(MEM_WORDS)) u_back (
      .clock       (clock),
      .reset       (reset),
      .cmd_empty   (cmd_empty),
      .cmd_data    (cmd_out),
      .cmd_pop     (cmd_pop),
      .res_full    (res_full),
      .res_push    (res_push),
      .res_data    (res_in),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data)
   );

   // octree word storage
   obl_ram #(.WIDTH(32), .DEPTH(MEM_WORDS)) u_words (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // response queue
   obl_fifo #(.WIDTH($bits(rsp_type)), .DEPTH(RSP_DEPTH)) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (res_push),
      .push_data (res_in),
      .full      (res_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_data),
      .empty     (rsp_empty)
   );

endmodule

`default_nettype wire
